// ----- rtl/clqrc_pkg.sv -----
`timescale 1ns / 1ps

package clqrc_pkg;

   localparam int MAX_ROW_LENGTH_DEFAULT = 256;

   // row sense codes
   localparam logic [1:0] SENSE_LE     = 2'd0;
   localparam logic [1:0] SENSE_GE     = 2'd1;
   localparam logic [1:0] SENSE_EQ     = 2'd2;
   localparam logic [1:0] SENSE_RANGED = 2'd3;

   // row class codes
   localparam logic [1:0] CLASS_NONE       = 2'd0;
   localparam logic [1:0] CLASS_REJECTED   = 2'd1;
   localparam logic [1:0] CLASS_PLAIN      = 2'd2;
   localparam logic [1:0] CLASS_COMPLEMENT = 2'd3;

   // Q32.32 constants
   localparam logic signed [63:0] Q_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_MIN     = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] Q_ONE     = 64'sh0000_0001_0000_0000;
   localparam logic signed [63:0] Q_E5      = 64'sd42950;
   localparam logic signed [63:0] Q_E8      = 64'sd43;
   localparam logic signed [63:0] Q_NEG_E5  = -64'sd42950;
   localparam logic signed [63:0] Q_NEG_E8  = -64'sd43;
   localparam logic signed [63:0] Q_ONE_E8  = 64'sh0000_0001_0000_002B;
   localparam logic signed [63:0] Q_BIGNEG  = -64'sd429496729600000000;
   localparam logic signed [64:0] Q_E8_W    = 65'sd43;
   localparam logic signed [64:0] Q_NEG_E8_W = -65'sd43;

   typedef struct packed {
      logic signed [63:0] coefficient;
      logic               var_is_integer;
      logic signed [63:0] lower_bound;
      logic signed [63:0] upper_bound;
      logic [1:0]         row_sense;
      logic signed [63:0] right_side;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic [1:0] row_class;
      logic [8:0] element_count;
      logic [8:0] minus_one_count;
   } rsp_type;

   // per-element evaluation handed to the aggregate registers
   typedef struct packed {
      logic               bad;
      logic               one_hit;
      logic               minus_hit;
      logic signed [63:0] adj_dbl;
   } elem_type;

   function automatic logic signed [63:0] sat_neg(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = (v == Q_MIN) ? Q_MAX : -v;
      return r;
   endfunction

   // saturating 2*v
   function automatic logic signed [63:0] sat_dbl(input logic signed [63:0] v);
      logic signed [63:0] r;
      if (v[63] != v[62]) begin
         r = v[63] ? Q_MIN : Q_MAX;
      end else begin
         r = {v[62:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- rtl/clqrc_elem.sv -----
`timescale 1ns / 1ps

module clqrc_elem (
   input  clqrc_pkg::req_type  item,
   output clqrc_pkg::elem_type elem
);

   logic               neg;
   logic signed [63:0] adj;
   logic signed [64:0] d_one;
   logic signed [64:0] d_mone;
   logic               binary;

   always_comb begin
      neg = (item.row_sense == clqrc_pkg::SENSE_GE);
      adj = neg ? clqrc_pkg::sat_neg(item.coefficient) : item.coefficient;
      d_one  = {adj[63], adj} - {clqrc_pkg::Q_ONE[63], clqrc_pkg::Q_ONE};
      d_mone = {adj[63], adj} + {clqrc_pkg::Q_ONE[63], clqrc_pkg::Q_ONE};
      binary = (item.lower_bound >= clqrc_pkg::Q_NEG_E8) &&
               (item.upper_bound <= clqrc_pkg::Q_ONE_E8);

      elem.bad = !item.var_is_integer ||
                 (item.lower_bound <= clqrc_pkg::Q_NEG_E5) ||
                 ((item.coefficient <= clqrc_pkg::Q_BIGNEG) &&
                  (item.upper_bound >= clqrc_pkg::Q_ONE_E8));
      elem.one_hit   = binary && (d_one >= clqrc_pkg::Q_NEG_E8_W) &&
                       (d_one <= clqrc_pkg::Q_E8_W);
      // a coefficient near one never also counts as minus one
      elem.minus_hit = binary && !elem.one_hit &&
                       (d_mone >= clqrc_pkg::Q_NEG_E8_W) &&
                       (d_mone <= clqrc_pkg::Q_E8_W);
      elem.adj_dbl   = clqrc_pkg::sat_dbl(adj);
   end

endmodule

// ----- rtl/clqrc_decide.sv -----
`timescale 1ns / 1ps

module clqrc_decide #(
   parameter int MAX_ROW_LENGTH = clqrc_pkg::MAX_ROW_LENGTH_DEFAULT,
   parameter int CW             = $clog2(MAX_ROW_LENGTH + 2)
) (
   input  logic [CW-1:0]        seen,
   input  logic                 vars_ok,
   input  logic [CW-1:0]        ones,
   input  logic [CW-1:0]        minus_ones,
   input  logic signed [63:0]   min_dbl,
   input  logic [1:0]           sense,
   input  logic signed [63:0]   rhs,
   output clqrc_pkg::rsp_type   rsp
);

   localparam logic [CW-1:0] LEN_MAX = CW'(MAX_ROW_LENGTH);
   localparam logic [CW-1:0] LEN_ONE = CW'(1);

   logic               reject;
   logic signed [63:0] m_rhs;
   logic signed [63:0] thr;
   logic               plain;
   logic [31:0]        k;
   logic signed [63:0] target;
   logic signed [64:0] diff;
   logic [CW:0]        covered;
   logic               compl_ok;
   logic [CW+8:0]      seen_ext;
   logic [CW+8:0]      mo_ext;

   always_comb begin
      reject = (seen <= LEN_ONE) || (seen > LEN_MAX) ||
               (sense == clqrc_pkg::SENSE_RANGED) || !vars_ok;
      m_rhs = (sense == clqrc_pkg::SENSE_GE) ? clqrc_pkg::sat_neg(rhs) : rhs;
      thr = (m_rhs > (clqrc_pkg::Q_MAX - clqrc_pkg::Q_E5)) ? clqrc_pkg::Q_MAX
                                                         : m_rhs + clqrc_pkg::Q_E5;
      plain = (min_dbl >= thr) && (rhs >= clqrc_pkg::Q_E5);

      // target (1 - minus_ones) in Q32.32, integer part only
      k = 32'd1 - 32'(minus_ones);
      target = {k, 32'h0};
      diff = {rhs[63], rhs} - {target[63], target};
      covered = {1'b0, ones} + {1'b0, minus_ones};
      compl_ok = (covered == {1'b0, seen}) &&
                 (diff >= clqrc_pkg::Q_NEG_E8_W) && (diff <= clqrc_pkg::Q_E8_W);

      if (reject) begin
         rsp.row_class = clqrc_pkg::CLASS_REJECTED;
      end else if (plain) begin
         rsp.row_class = clqrc_pkg::CLASS_PLAIN;
      end else if (compl_ok) begin
         rsp.row_class = clqrc_pkg::CLASS_COMPLEMENT;
      end else begin
         rsp.row_class = clqrc_pkg::CLASS_NONE;
      end

      seen_ext = {9'b0, seen};
      mo_ext   = {9'b0, minus_ones};
      rsp.element_count   = seen_ext[8:0];
      rsp.minus_one_count = mo_ext[8:0];
   end

endmodule

// ----- rtl/clique_row_classifier_unit.sv -----
`timescale 1ns / 1ps

// Classifies a constraint row streamed one nonzero per beat as a set-packing
// clique. Every beat is taken into an input register; from there it is
// checked, folded into the running row aggregates (validity, least adjusted
// coefficient, +1 and -1 counts), and on the beat marked last the class and
// counts go to an output register, and the aggregates clear for the next row.
// One beat per clock is sustained; a row's result goes to the output register
// as its last beat advances. The input register only waits while a result sits
// stalled in the output register. Counters saturate at MAX_ROW_LENGTH+1.
module clique_row_classifier_unit #(
   parameter int MAX_ROW_LENGTH = clqrc_pkg::MAX_ROW_LENGTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  clqrc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output clqrc_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_ROW_LENGTH + 2);
   localparam logic [CW-1:0] CNT_SAT = CW'(MAX_ROW_LENGTH + 1);

   clqrc_pkg::req_type  in_ff;
   logic                in_valid_ff;
   clqrc_pkg::rsp_type  rsp_ff;
   logic                rsp_valid_ff;

   logic                vars_ok_ff, vars_ok_in;
   logic signed [63:0]  min_ff, min_in;
   logic [CW-1:0]       ones_ff, ones_in;
   logic [CW-1:0]       minus_ff, minus_in;
   logic [CW-1:0]       seen_ff, seen_in;

   clqrc_pkg::elem_type elem;
   clqrc_pkg::rsp_type  result;
   logic                advance;
   logic                good;
   logic signed [63:0]  min_dbl_cur;
   logic signed [63:0]  min_dbl;

   clqrc_elem u_elem (
      .item (in_ff),
      .elem (elem)
   );

   always_comb begin
      advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
      req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
      good      = vars_ok_ff && !elem.bad;

      seen_in    = (seen_ff == CNT_SAT) ? seen_ff : seen_ff + CW'(1);
      vars_ok_in = good;
      ones_in    = ones_ff;
      minus_in   = minus_ff;
      min_in     = min_ff;
      if (good) begin
         if (elem.one_hit && ones_ff != CNT_SAT) begin
            ones_in = ones_ff + CW'(1);
         end
         if (elem.minus_hit && minus_ff != CNT_SAT) begin
            minus_in = minus_ff + CW'(1);
         end
         // adjusted coefficient is the input coefficient, possibly negated
         if (in_ff.row_sense == clqrc_pkg::SENSE_GE) begin
            if (clqrc_pkg::sat_neg(in_ff.coefficient) < min_ff) begin
               min_in = clqrc_pkg::sat_neg(in_ff.coefficient);
            end
         end else if (in_ff.coefficient < min_ff) begin
            min_in = in_ff.coefficient;
         end
      end

      // doubling saturates monotonically, so min of doubles is double of min
      min_dbl_cur = clqrc_pkg::sat_dbl(min_ff);
      min_dbl = (good && elem.adj_dbl < min_dbl_cur) ? elem.adj_dbl : min_dbl_cur;
   end

   clqrc_decide #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
      .CW             (CW)
   ) u_decide (
      .seen       (seen_in),
      .vars_ok    (vars_ok_in),
      .ones       (ones_in),
      .minus_ones (minus_in),
      .min_dbl    (min_dbl),
      .sense      (in_ff.row_sense),
      .rhs        (in_ff.right_side),
      .rsp        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vars_ok_ff   <= 1'b1;
         min_ff       <= clqrc_pkg::Q_MAX;
         ones_ff      <= '0;
         minus_ff     <= '0;
         seen_ff      <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance && in_ff.last_element) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (advance) begin
            if (in_ff.last_element) begin
               vars_ok_ff <= 1'b1;
               min_ff     <= clqrc_pkg::Q_MAX;
               ones_ff    <= '0;
               minus_ff   <= '0;
               seen_ff    <= '0;
            end else begin
               vars_ok_ff <= vars_ok_in;
               min_ff     <= min_in;
               ones_ff    <= ones_in;
               minus_ff   <= minus_in;
               seen_ff    <= seen_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
      if (advance && in_ff.last_element) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
